FILE: sv/lmsf_pkg.sv
// Shared constants, command types and coefficient table for the LED sample filter.
package lmsf_pkg;

  // Field widths of the ports
  localparam int ADC_BITS      = 12;
  localparam int MODE_BITS     = 2;
  localparam int LED_BITS      = 2;
  localparam int OUT_BITS      = 24;
  localparam int OUT_FRAC_BITS = 8;
  localparam int CNT_BITS      = 16;

  // Filter arithmetic
  localparam int STATE_BITS    = 40;
  localparam int ACC_BITS      = STATE_BITS + 4;
  localparam int SPLIT_BITS    = 16;
  localparam int Q29_FRAC      = 29;
  localparam int NUM_TERMS     = 10;
  localparam int TERM_IDX_BITS = 4;
  localparam int STEP_BITS     = 5;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF     = 12;
  localparam int COEF_FRAC_BITS_DEF  = 29;
  localparam int STATE_FRAC_BITS_DEF = 16;

  localparam logic [CNT_BITS-1:0] CAPTURE_LIMIT_RESET = 16'd3000;

  localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [OUT_BITS-1:0]   OUT_MAX   = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0]   OUT_MIN   = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Transaction modes
  localparam logic [MODE_BITS-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CLR_FILT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLR_CAP  = 2'd2;

  // LED drive codes
  localparam logic [LED_BITS-1:0] LED_OFF = 2'd0;
  localparam logic [LED_BITS-1:0] LED_RED = 2'd1;
  localparam logic [LED_BITS-1:0] LED_IR  = 2'd2;

  // Multiplier pass: low or high half of the state operand
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  // Order of the products; the low-pass input term comes last so that the
  // high-pass result is ready by then.
  localparam logic [TERM_IDX_BITS-1:0] TERM_HP_X  = 4'd0;
  localparam logic [TERM_IDX_BITS-1:0] TERM_HP_X1 = 4'd1;
  localparam logic [TERM_IDX_BITS-1:0] TERM_HP_X2 = 4'd2;
  localparam logic [TERM_IDX_BITS-1:0] TERM_HP_Y1 = 4'd3;
  localparam logic [TERM_IDX_BITS-1:0] TERM_HP_Y2 = 4'd4;
  localparam logic [TERM_IDX_BITS-1:0] TERM_LP_X1 = 4'd5;
  localparam logic [TERM_IDX_BITS-1:0] TERM_LP_X2 = 4'd6;
  localparam logic [TERM_IDX_BITS-1:0] TERM_LP_Y1 = 4'd7;
  localparam logic [TERM_IDX_BITS-1:0] TERM_LP_Y2 = 4'd8;
  localparam logic [TERM_IDX_BITS-1:0] TERM_LP_X  = 4'd9;

  // Q2.29 coefficients in product order
  localparam logic signed [63:0] COEF_Q29 [NUM_TERMS] = '{
    64'sd535441665,     // high-pass b0
    -64'sd1070883330,   // high-pass b1
    64'sd535441665,     // high-pass b2
    -64'sd1070879525,   // high-pass a1
    64'sd534016223,     // high-pass a2
    64'sd1448168,       // low-pass b1
    64'sd724084,        // low-pass b2
    -64'sd1016545823,   // low-pass a1
    64'sd482571248,     // low-pass a2
    64'sd724084         // low-pass b0
  };

  // Coefficient of one product, rescaled to the chosen fraction width
  function automatic logic signed [63:0] coef_q(input logic [TERM_IDX_BITS-1:0] idx,
                                                input int unsigned cfb);
    logic signed [63:0] c;
    c = '0;
    if (idx < TERM_IDX_BITS'(NUM_TERMS)) begin
      c = COEF_Q29[idx];
    end
    if (cfb >= Q29_FRAC) begin
      return c <<< (cfb - Q29_FRAC);
    end
    return c >>> (Q29_FRAC - cfb);
  endfunction

  // The first product of each biquad loads the accumulator
  function automatic logic term_first(input logic [TERM_IDX_BITS-1:0] idx);
    return (idx == TERM_HP_X) || (idx == TERM_LP_X1);
  endfunction

  // Feedback products are subtracted
  function automatic logic term_sub(input logic [TERM_IDX_BITS-1:0] idx);
    return (idx == TERM_HP_Y1) || (idx == TERM_HP_Y2) ||
           (idx == TERM_LP_Y1) || (idx == TERM_LP_Y2);
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                     load;
    logic                     chan;
    logic                     clr_filt;
    logic                     clr_count;
    mul_op_t                  mul_op;
    logic [TERM_IDX_BITS-1:0] term_idx;
    logic                     res_load;
    logic                     res_sample;
    logic [LED_BITS-1:0]      led;
  } lmsf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic filt_done;
  } lmsf_sts_t;

endpackage

FILE: sv/lmsf_ctrl.sv
// Controller: LED phase sequencer, handshakes and multiply sequence.
module lmsf_ctrl
  import lmsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_BITS-1:0] in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lmsf_cmd_t            cmd,
  input  lmsf_sts_t            sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PUT
  } state_t;

  localparam logic [1:0] PHASE_RED_ON = 2'd1;
  localparam logic [1:0] PHASE_IR_ON  = 2'd3;
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(2 * NUM_TERMS - 1);

  state_t               state_r;
  logic [1:0]           phase_r;
  logic [STEP_BITS-1:0] step_r;
  logic                 sampled_r;
  logic                 out_valid_r;
  logic                 accept;
  logic                 out_free;
  logic                 sample_tick;

  assign out_valid   = out_valid_r;
  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign sample_tick = (in_mode == MODE_TICK) && phase_r[0];

  // Commands decoded from the state
  always_comb begin
    cmd            = '0;
    cmd.mul_op     = MUL_NONE;
    cmd.term_idx   = step_r[STEP_BITS-1:1];
    cmd.res_sample = sampled_r;
    cmd.chan       = (phase_r == PHASE_IR_ON);
    if (phase_r == PHASE_RED_ON) begin
      cmd.led = LED_RED;
    end else if (phase_r == PHASE_IR_ON) begin
      cmd.led = LED_IR;
    end else begin
      cmd.led = LED_OFF;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_TICK:     cmd.load      = phase_r[0];
            MODE_CLR_FILT: cmd.clr_filt  = 1'b1;
            MODE_CLR_CAP:  cmd.clr_count = 1'b1;
            default:       ;
          endcase
        end
      end
      ST_MAC:   cmd.mul_op   = step_r[0] ? MUL_HI : MUL_LO;
      ST_DRAIN: ;
      ST_PUT:   cmd.res_load = out_free;
      default:  ;
    endcase
  end

  // State, phase and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      step_r      <= '0;
      sampled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result valid rises as a result is loaded and falls once it is taken.
      if ((state_r == ST_PUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            step_r    <= '0;
            sampled_r <= sample_tick;
            if (sample_tick) begin
              state_r <= ST_MAC;
            end else begin
              state_r <= ST_PUT;
            end
            unique case (in_mode)
              MODE_TICK:    phase_r <= phase_r + 2'd1;
              MODE_CLR_CAP: phase_r <= '0;
              default:      ;
            endcase
          end
        end
        ST_MAC: begin
          step_r <= step_r + STEP_BITS'(1);
          if (step_r == STEP_LAST) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (sts.filt_done) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/lmsf_datapath.sv
// Datapath: shared multiplier, accumulator, filter history, counters and result register.
module lmsf_datapath
  import lmsf_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lmsf_cmd_t                  cmd,
  output lmsf_sts_t                  sts,
  input  logic [ADC_BITS-1:0]        in_adc_sample,
  input  logic                       cfg_wr_en,
  input  logic [CNT_BITS-1:0]        cfg_wr_data,
  output logic [LED_BITS-1:0]        out_led_drive,
  output logic                       out_sample_valid,
  output logic                       out_channel,
  output logic [ADC_BITS-1:0]        out_raw_sample,
  output logic signed [OUT_BITS-1:0] out_filtered_sample,
  output logic                       out_store_enable,
  output logic [CNT_BITS-1:0]        out_store_index
);

  localparam int SMP_W      = (SAMPLE_BITS < ADC_BITS) ? SAMPLE_BITS : ADC_BITS;
  localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
  localparam int MUL_B_BITS = STATE_BITS - SPLIT_BITS + 1;
  localparam int PROD_BITS  = COEF_BITS + MUL_B_BITS;
  localparam int FULL_BITS  = PROD_BITS + SPLIT_BITS;

  // Captured reading and channel
  logic [SMP_W-1:0] sample_r;
  logic             chan_r;

  // Filter history
  logic [SMP_W-1:0]              hp_in_prev1_r, hp_in_prev2_r;
  logic signed [STATE_BITS-1:0]  hp_out_prev1_r, hp_out_prev2_r;
  logic signed [STATE_BITS-1:0]  lp_in_prev1_r, lp_in_prev2_r;
  logic signed [STATE_BITS-1:0]  lp_out_prev1_r, lp_out_prev2_r;
  logic signed [STATE_BITS-1:0]  hp_r;
  logic signed [OUT_BITS-1:0]    filt_r;

  // Multiply and accumulate pipeline
  logic signed [COEF_BITS-1:0]   coef_sel;
  logic signed [63:0]            coef_full;
  logic signed [STATE_BITS-1:0]  src_s;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]   prod_nxt, prod_lo_r, prod_hi_r;
  logic                          hi_vld_r;
  logic [TERM_IDX_BITS-1:0]      hi_idx_r;
  logic signed [FULL_BITS-1:0]   full_prod, full_shift;
  logic signed [ACC_BITS-1:0]    term_nxt, term_r;
  logic                          term_vld_r;
  logic [TERM_IDX_BITS-1:0]      term_idx_r;
  logic signed [ACC_BITS-1:0]    acc_base, acc_nxt, acc_r;
  logic                          hp_cap_r, lp_cap_r;
  logic [ACC_BITS-STATE_BITS:0]  acc_top;
  logic signed [STATE_BITS-1:0]  acc_sat;
  logic signed [STATE_BITS-1:0]  lp_shift;
  logic [STATE_BITS-OUT_BITS:0]  lp_top;
  logic signed [OUT_BITS-1:0]    out_sat;

  // Capture counters and limit
  logic [CNT_BITS-1:0] red_cnt_r, ir_cnt_r, cap_limit_r;
  logic [CNT_BITS-1:0] cnt_sel, cnt_inc;
  logic                store_en;

  // Result register
  logic [LED_BITS-1:0]        led_r;
  logic                       smp_vld_r, chan_out_r, store_en_r;
  logic [ADC_BITS-1:0]        raw_r;
  logic signed [OUT_BITS-1:0] filt_out_r;
  logic [CNT_BITS-1:0]        store_idx_r;

  assign sts.filt_done = lp_cap_r;

  // Coefficient and state operand for the current product
  assign coef_full = coef_q(cmd.term_idx, COEF_FRAC_BITS);
  assign coef_sel  = coef_full[COEF_BITS-1:0];

  always_comb begin
    unique case (cmd.term_idx)
      TERM_HP_X:  src_s = $signed(STATE_BITS'(sample_r) << STATE_FRAC_BITS);
      TERM_HP_X1: src_s = $signed(STATE_BITS'(hp_in_prev1_r) << STATE_FRAC_BITS);
      TERM_HP_X2: src_s = $signed(STATE_BITS'(hp_in_prev2_r) << STATE_FRAC_BITS);
      TERM_HP_Y1: src_s = hp_out_prev1_r;
      TERM_HP_Y2: src_s = hp_out_prev2_r;
      TERM_LP_X1: src_s = lp_in_prev1_r;
      TERM_LP_X2: src_s = lp_in_prev2_r;
      TERM_LP_Y1: src_s = lp_out_prev1_r;
      TERM_LP_Y2: src_s = lp_out_prev2_r;
      TERM_LP_X:  src_s = hp_r;
      default:    src_s = '0;
    endcase
  end

  // The low-half pass takes the unsigned low half, the high-half pass the signed upper part
  always_comb begin
    if (cmd.mul_op == MUL_HI) begin
      mul_b = MUL_B_BITS'($signed(src_s[STATE_BITS-1:SPLIT_BITS]));
    end else begin
      mul_b = $signed(MUL_B_BITS'(src_s[SPLIT_BITS-1:0]));
    end
  end

  assign prod_nxt = PROD_BITS'(coef_sel) * PROD_BITS'(mul_b);

  // Joining both halves gives the exact product; the arithmetic shift floors it
  assign full_prod  = (FULL_BITS'(prod_hi_r) <<< SPLIT_BITS) + FULL_BITS'(prod_lo_r);
  assign full_shift = full_prod >>> COEF_FRAC_BITS;
  assign term_nxt   = ACC_BITS'(full_shift);

  // Accumulator: first product of a biquad loads, feedback products subtract
  assign acc_base = term_first(term_idx_r) ? '0 : acc_r;
  assign acc_nxt  = term_sub(term_idx_r) ? (acc_base - term_r) : (acc_base + term_r);

  // Saturate the accumulator to the state width
  assign acc_top = acc_r[ACC_BITS-1:STATE_BITS-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      acc_sat = acc_r[STATE_BITS-1:0];
    end else begin
      acc_sat = acc_r[ACC_BITS-1] ? STATE_MIN : STATE_MAX;
    end
  end

  // Floor to eight fraction bits and saturate to the output width
  assign lp_shift = acc_sat >>> (STATE_FRAC_BITS - OUT_FRAC_BITS);
  assign lp_top   = lp_shift[STATE_BITS-1:OUT_BITS-1];
  always_comb begin
    if ((&lp_top) || !(|lp_top)) begin
      out_sat = lp_shift[OUT_BITS-1:0];
    end else begin
      out_sat = lp_shift[STATE_BITS-1] ? OUT_MIN : OUT_MAX;
    end
  end

  // Capture counter of the sampled channel
  assign cnt_sel  = chan_r ? ir_cnt_r : red_cnt_r;
  assign store_en = (cnt_sel < cap_limit_r);
  assign cnt_inc  = cnt_sel + CNT_BITS'(1);

  // Pipeline flags, filter history, counters and the limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_vld_r       <= 1'b0;
      term_vld_r     <= 1'b0;
      hp_cap_r       <= 1'b0;
      lp_cap_r       <= 1'b0;
      hp_in_prev1_r  <= '0;
      hp_in_prev2_r  <= '0;
      hp_out_prev1_r <= '0;
      hp_out_prev2_r <= '0;
      lp_in_prev1_r  <= '0;
      lp_in_prev2_r  <= '0;
      lp_out_prev1_r <= '0;
      lp_out_prev2_r <= '0;
      red_cnt_r      <= '0;
      ir_cnt_r       <= '0;
      cap_limit_r    <= CAPTURE_LIMIT_RESET;
    end else begin
      hi_vld_r   <= (cmd.mul_op == MUL_HI);
      term_vld_r <= hi_vld_r;
      hp_cap_r   <= term_vld_r && (term_idx_r == TERM_HP_Y2);
      lp_cap_r   <= term_vld_r && (term_idx_r == TERM_LP_X);

      if (cfg_wr_en) begin
        cap_limit_r <= cfg_wr_data;
      end

      if (cmd.clr_filt) begin
        hp_in_prev1_r  <= '0;
        hp_in_prev2_r  <= '0;
        hp_out_prev1_r <= '0;
        hp_out_prev2_r <= '0;
        lp_in_prev1_r  <= '0;
        lp_in_prev2_r  <= '0;
        lp_out_prev1_r <= '0;
        lp_out_prev2_r <= '0;
      end else if (lp_cap_r) begin
        hp_in_prev2_r  <= hp_in_prev1_r;
        hp_in_prev1_r  <= sample_r;
        hp_out_prev2_r <= hp_out_prev1_r;
        hp_out_prev1_r <= hp_r;
        lp_in_prev2_r  <= lp_in_prev1_r;
        lp_in_prev1_r  <= hp_r;
        lp_out_prev2_r <= lp_out_prev1_r;
        lp_out_prev1_r <= acc_sat;
      end

      if (cmd.clr_count) begin
        red_cnt_r <= '0;
        ir_cnt_r  <= '0;
      end else if (cmd.res_load && cmd.res_sample && store_en) begin
        if (chan_r) begin
          ir_cnt_r <= cnt_inc;
        end else begin
          red_cnt_r <= cnt_inc;
        end
      end
    end
  end

  // Working registers of the multiply sequence
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_adc_sample[SMP_W-1:0];
      chan_r   <= cmd.chan;
    end
    if (cmd.mul_op == MUL_LO) begin
      prod_lo_r <= prod_nxt;
    end
    if (cmd.mul_op == MUL_HI) begin
      prod_hi_r <= prod_nxt;
      hi_idx_r  <= cmd.term_idx;
    end
    if (hi_vld_r) begin
      term_r     <= term_nxt;
      term_idx_r <= hi_idx_r;
    end
    if (term_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (hp_cap_r) begin
      hp_r <= acc_sat;
    end
    if (lp_cap_r) begin
      filt_r <= out_sat;
    end
  end

  // Result register, loaded once the output side is free
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      led_r <= cmd.led;
      if (cmd.res_sample) begin
        smp_vld_r   <= 1'b1;
        chan_out_r  <= chan_r;
        raw_r       <= ADC_BITS'(sample_r);
        filt_out_r  <= filt_r;
        store_en_r  <= store_en;
        store_idx_r <= store_en ? cnt_sel : '0;
      end else begin
        smp_vld_r   <= 1'b0;
        chan_out_r  <= 1'b0;
        raw_r       <= '0;
        filt_out_r  <= '0;
        store_en_r  <= 1'b0;
        store_idx_r <= '0;
      end
    end
  end

  assign out_led_drive       = led_r;
  assign out_sample_valid    = smp_vld_r;
  assign out_channel         = chan_out_r;
  assign out_raw_sample      = raw_r;
  assign out_filtered_sample = filt_out_r;
  assign out_store_enable    = store_en_r;
  assign out_store_index     = store_idx_r;

endmodule

FILE: sv/led_multiplexed_sample_filter.sv
// A sampling tick makes ten products a reading on the single shared multiplier, two passes per
// product (ST_MAC), waits for the filter result (ST_DRAIN) and loads the result register (ST_PUT);
// any other transaction goes straight to ST_PUT. A new transaction is taken only in ST_IDLE.
// Reset (rst_n, synchronous, active low) zeroes the phase, filter history and capture counts
// and sets the capture limit to 3000; no clearing pass is needed.
// Top level: LED phase sequencer with a shared high-pass and low-pass biquad chain.
module led_multiplexed_sample_filter
  import lmsf_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
  parameter int STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_BITS-1:0]       in_mode,
  input  logic [ADC_BITS-1:0]        in_adc_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LED_BITS-1:0]        out_led_drive,
  output logic                       out_sample_valid,
  output logic                       out_channel,
  output logic [ADC_BITS-1:0]        out_raw_sample,
  output logic signed [OUT_BITS-1:0] out_filtered_sample,
  output logic                       out_store_enable,
  output logic [CNT_BITS-1:0]        out_store_index,
  input  logic                       cfg_wr_en,
  input  logic [CNT_BITS-1:0]        cfg_wr_data
);

  lmsf_cmd_t cmd;
  lmsf_sts_t sts;

  // Sequencer and handshakes
  lmsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic, history, counters and result register
  lmsf_datapath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_adc_sample       (in_adc_sample),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_led_drive       (out_led_drive),
    .out_sample_valid    (out_sample_valid),
    .out_channel         (out_channel),
    .out_raw_sample      (out_raw_sample),
    .out_filtered_sample (out_filtered_sample),
    .out_store_enable    (out_store_enable),
    .out_store_index     (out_store_index)
  );

endmodule

FILE: sv/lmsf_checker.sv
// Port-level checks on the result channel, bound to the top level.
module lmsf_checker
  import lmsf_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [LED_BITS-1:0]        out_led_drive,
  input logic                       out_sample_valid,
  input logic                       out_channel,
  input logic [ADC_BITS-1:0]        out_raw_sample,
  input logic signed [OUT_BITS-1:0] out_filtered_sample,
  input logic                       out_store_enable,
  input logic [CNT_BITS-1:0]        out_store_index
);

  // A transaction without a reading carries nothing but the LED state.
  a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |->
      out_channel == 1'b0 && out_raw_sample == '0 && out_filtered_sample == '0 &&
      out_store_enable == 1'b0 && out_store_index == '0)
    else $error("non-sampling transaction carries sample fields");

  // LEDs are switched off on every sampling step.
  a_leds_off_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_valid |-> out_led_drive == LED_OFF)
    else $error("LED left on after a sampling transaction");

  // An index is only handed out while storing is enabled.
  a_store_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_store_enable |-> out_store_index == '0)
    else $error("store index given without store enable");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_filtered_sample) && $stable(out_store_index) &&
      $stable(out_led_drive) && $stable(out_raw_sample))
    else $error("result changed while stalled");

endmodule

bind led_multiplexed_sample_filter lmsf_checker u_lmsf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_led_drive       (out_led_drive),
  .out_sample_valid    (out_sample_valid),
  .out_channel         (out_channel),
  .out_raw_sample      (out_raw_sample),
  .out_filtered_sample (out_filtered_sample),
  .out_store_enable    (out_store_enable),
  .out_store_index     (out_store_index)
);
